// ===== design/distance_gesture_classifier_macros.svh =====
// ----------------------------------------------------------------------------
// distance gesture classifier assertion macros
// concurrent check wrappers, compiled out when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef DISTANCE_GESTURE_CLASSIFIER_MACROS_SVH
`define DISTANCE_GESTURE_CLASSIFIER_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define DGC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dgc check failed: same-cycle implication");
// next-cycle implication
`define DGC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dgc check failed: next-cycle implication");
`else
`define DGC_ASSERT_IMP(label, clk, rst, ante, cons)
`define DGC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== design/dgc_pkg.sv =====
// ----------------------------------------------------------------------------
// dgc_pkg
// shared types and constants of the distance gesture classifier
// ----------------------------------------------------------------------------
package dgc_pkg;

  // gesture codes
  localparam logic [2:0] G_NONE  = 3'd0;
  localparam logic [2:0] G_WAVE  = 3'd1;
  localparam logic [2:0] G_PUSH  = 3'd2;
  localparam logic [2:0] G_HOLD  = 3'd3;
  localparam logic [2:0] G_SWIPE = 3'd4;

  // transaction opcodes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_POLL   = 1'b1;

  // configuration register indexes
  localparam logic [2:0] R_HOLD_NEAR   = 3'd0;
  localparam logic [2:0] R_HOLD_SPREAD = 3'd1;
  localparam logic [2:0] R_HOLD_TICKS  = 3'd2;
  localparam logic [2:0] R_SWIPE_NEAR  = 3'd3;
  localparam logic [2:0] R_SWIPE_TICKS = 3'd4;
  localparam logic [2:0] R_COOLDOWN    = 3'd5;
  localparam logic [2:0] R_WAVE_AMP    = 3'd6;
  localparam logic [2:0] R_PUSH_DEPTH  = 3'd7;

  // scan and divider lengths
  localparam logic [3:0] SCAN_LEN  = 4'd13;
  localparam logic [3:0] DIV_STEPS = 4'd13;

  // saturation caps and thresholds
  localparam logic [4:0] SEEN_CAP   = 5'd20;
  localparam logic [7:0] TICK_CAP   = 8'd255;
  localparam logic [7:0] NEAR_TICKS = 8'd3;

  // controller to datapath commands
  typedef struct packed {
    logic start;
    logic issue;
    logic div_init;
    logic div_step;
    logic finish;
    logic poll;
  } dgc_cmd_t;

endpackage

// ===== design/distance_gesture_classifier.sv =====
// ----------------------------------------------------------------------------
// distance_gesture_classifier
// classifies hand gestures from a stream of distance samples
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries opcode and distance_cm: a sample
// (opcode 0) or a poll (opcode 1). Every input transaction yields exactly one
// result on out_valid/out_ready: gesture, hand_near and average_cm.
// A sample runs through these steps in order: the write on the accept
// edge, thirteen reads of the history memory (one read port, newest first),
// a drain state, thirteen steps of a bit-serial divider for the mean and
// the load of the result register. A poll goes straight to the finish
// state. Either result is registered only once the output register is free.
// One item is in flight at a time and the input is ready again once the
// result is registered.
// The input is taken while an earlier result still sits in the output
// register; if the receiver stalls, the block waits before updating gesture
// state until that result is taken. Configuration writes on cfg_valid with
// cfg_index/cfg_data are always ready and should be made while idle.
// Reset restores register defaults, marks all history entries as no echo
// and clears the pending gesture and counters; no clearing pass is needed.
// ----------------------------------------------------------------------------
module distance_gesture_classifier #(
  parameter int HISTORY_DEPTH = 20
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               opcode,
  input  logic signed [10:0] distance_cm,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         gesture,
  output logic               hand_near,
  output logic signed [10:0] average_cm,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [9:0]         cfg_data
);
  import dgc_pkg::*;

  dgc_cmd_t cmd;

  assign cfg_ready = 1'b1;

  // sequencer
  dgc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // history, scan and gesture state
  dgc_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .distance_cm (distance_cm),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .gesture     (gesture),
    .hand_near   (hand_near),
    .average_cm  (average_cm)
  );

endmodule

// ===== design/dgc_datapath.sv =====
// ----------------------------------------------------------------------------
// dgc_datapath
// history memory, scan accumulators, mean divider and gesture state
// ----------------------------------------------------------------------------
module dgc_datapath #(
  parameter int HISTORY_DEPTH = 20
) (
  input  logic                clk,
  input  logic                rst,
  input  dgc_pkg::dgc_cmd_t   cmd,
  input  logic signed [10:0]  distance_cm,
  input  logic                cfg_valid,
  input  logic [2:0]          cfg_index,
  input  logic [9:0]          cfg_data,
  output logic [2:0]          gesture,
  output logic                hand_near,
  output logic signed [10:0]  average_cm
);
  import dgc_pkg::*;

  localparam int AW = $clog2(HISTORY_DEPTH);

  // configuration registers
  logic [9:0] hold_near, hold_spread, swipe_near, wave_amp, push_dep;
  logic [7:0] hold_ticks, cool_ticks;
  logic [2:0] swipe_ticks;

  // history and block state
  logic signed [10:0]       mem [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0] hvld;
  logic [AW-1:0]            write_slot, raddr;
  logic [4:0]               samples_seen;
  logic [2:0]               pending;
  logic [7:0]               close_ticks, cooldown;
  logic signed [10:0]       avg_q, samp;

  // read stage
  logic [3:0]         ago_cnt, k;
  logic signed [10:0] rd_data, d, pd;
  logic               rd_ok, acc_en;

  // accumulators
  logic       w_any;
  logic [9:0] w_hi, w_lo;
  logic [1:0] w_dir, dir;
  logic [3:0] w_chg;
  logic       p_pos_v, p_bef_v, p_aft_v, p_last_v;
  logic [3:0] p_pos;
  logic [9:0] p_lo, p_bef, p_aft, p_last;
  logic       s_start_v, s_found;
  logic [3:0] s_start, s_len;
  logic [12:0] f_sum;
  logic [2:0]  f_n;
  logic [9:0]  f_hi, f_lo;

  // divider
  logic [2:0]  dv_rem;
  logic [12:0] dv_q;
  logic [3:0]  rem2;
  logic        dv_ge;

  // scan decode
  logic dpos, kin_seen, w_act, p_min, p_bef_hit, s_act, s_zone, f_act;
  // finish decode
  logic               close, hold_ok, wave_ok, push_ok, swipe_ok;
  logic [7:0]         ct_inc, cool_next;
  logic [2:0]         pg_h, pg_next;
  logic signed [10:0] mean;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_near   <= 10'd30;
      hold_spread <= 10'd8;
      hold_ticks  <= 8'd10;
      swipe_near  <= 10'd35;
      swipe_ticks <= 3'd6;
      cool_ticks  <= 8'd10;
      wave_amp    <= 10'd12;
      push_dep    <= 10'd25;
    end else if (cfg_valid) begin
      case (cfg_index)
        R_HOLD_NEAR:   hold_near   <= cfg_data;
        R_HOLD_SPREAD: hold_spread <= cfg_data;
        R_HOLD_TICKS:  hold_ticks  <= cfg_data[7:0];
        R_SWIPE_NEAR:  swipe_near  <= cfg_data;
        R_SWIPE_TICKS: swipe_ticks <= cfg_data[2:0];
        R_COOLDOWN:    cool_ticks  <= cfg_data[7:0];
        R_WAVE_AMP:    wave_amp    <= cfg_data;
        R_PUSH_DEPTH:  push_dep    <= cfg_data;
        default: ;
      endcase
    end
  end

  // history memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (cmd.start) mem[write_slot] <= distance_cm;
    if (cmd.issue) begin
      rd_data <= mem[raddr];
      rd_ok   <= hvld[raddr];
      k       <= ago_cnt;
    end
  end

  // entries never written read as no echo
  assign d = rd_ok ? rd_data : -11'sd1;

  // write pointer, fill marks and read walk
  always_ff @(posedge clk) begin
    if (rst) begin
      hvld         <= '0;
      write_slot   <= '0;
      samples_seen <= '0;
      acc_en       <= 1'b0;
    end else begin
      acc_en <= cmd.issue;
      if (cmd.start) begin
        hvld[write_slot] <= 1'b1;
        write_slot <= (write_slot == AW'(HISTORY_DEPTH - 1)) ? '0 : write_slot + 1'b1;
        if (samples_seen < SEEN_CAP) samples_seen <= samples_seen + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      raddr   <= write_slot;
      ago_cnt <= '0;
      samp    <= distance_cm;
    end else if (cmd.issue) begin
      raddr   <= (raddr == '0) ? AW'(HISTORY_DEPTH - 1) : raddr - 1'b1;
      ago_cnt <= ago_cnt + 4'd1;
    end
  end

  // per-entry decode
  assign dpos     = !d[10] && (d != 11'sd0);
  assign kin_seen = {1'b0, k} < samples_seen;

  // wave pairs back(k-1) with back(k); k never exceeds twelve
  assign w_act = acc_en && (k != 4'd0) && ({1'b0, 4'(k - 4'd1)} < samples_seen)
                 && !pd[10] && !d[10];
  assign dir   = (pd > d) ? 2'd1 : (pd < d) ? 2'd2 : 2'd0;

  // push minimum and the first positive sample beyond it
  assign p_min     = acc_en && (k < 4'd10) && kin_seen && dpos
                     && (!p_pos_v || d[9:0] < p_lo);
  assign p_bef_hit = acc_en && !p_min && p_pos_v && kin_seen && !p_bef_v && dpos
                     && ({1'b0, k} <= {1'b0, p_pos} + 5'd3);

  // swipe zone run tracking
  assign s_act  = acc_en && (k < 4'd8) && kin_seen && !s_found;
  assign s_zone = dpos && (d[9:0] < swipe_near);
  assign s_len  = k - s_start;

  // last five samples for hold spread and the mean
  assign f_act = acc_en && (k < 4'd5) && dpos;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      w_any <= 1'b0; w_dir <= 2'd0; w_chg <= '0;
      p_pos_v <= 1'b0; p_bef_v <= 1'b0; p_aft_v <= 1'b0; p_last_v <= 1'b0;
      s_start_v <= 1'b0; s_found <= 1'b0;
      f_sum <= '0; f_n <= '0;
    end else if (acc_en) begin
      pd <= d;
      if (w_act) begin
        w_any <= 1'b1;
        if (!w_any || pd[9:0] > w_hi) w_hi <= pd[9:0];
        if (!w_any || pd[9:0] < w_lo) w_lo <= pd[9:0];
        if (dir != 2'd0 && w_dir != 2'd0 && dir != w_dir) w_chg <= w_chg + 4'd1;
        if (dir != 2'd0) w_dir <= dir;
      end
      if (p_min) begin
        p_pos_v <= 1'b1;
        p_pos   <= k;
        p_lo    <= d[9:0];
        p_aft_v <= p_last_v;
        p_aft   <= p_last;
        p_bef_v <= 1'b0;
      end else if (p_bef_hit) begin
        p_bef_v <= 1'b1;
        p_bef   <= d[9:0];
      end
      if (dpos) begin
        p_last_v <= 1'b1;
        p_last   <= d[9:0];
      end
      if (s_act) begin
        if (s_zone) begin
          if (!s_start_v) begin
            s_start_v <= 1'b1;
            s_start   <= k;
          end
        end else if (s_start_v) begin
          if (s_len != 4'd0 && s_len <= {1'b0, swipe_ticks} && dpos
              && ({1'b0, d[9:0]} > {1'b0, swipe_near} + 11'd20))
            s_found <= 1'b1;
          s_start_v <= 1'b0;
        end
      end
      if (f_act) begin
        f_sum <= f_sum + {3'd0, d[9:0]};
        f_n   <= f_n + 3'd1;
        if (f_n == 3'd0 || d[9:0] > f_hi) f_hi <= d[9:0];
        if (f_n == 3'd0 || d[9:0] < f_lo) f_lo <= d[9:0];
      end
    end
  end

  // restoring divider, one quotient bit per step
  assign rem2  = {dv_rem, dv_q[12]};
  assign dv_ge = rem2 >= {1'b0, f_n};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      dv_rem <= '0;
      dv_q   <= f_sum;
    end else if (cmd.div_step) begin
      dv_rem <= dv_ge ? 3'(rem2 - {1'b0, f_n}) : rem2[2:0];
      dv_q   <= {dv_q[11:0], dv_ge};
    end
  end

  assign mean = (f_n == 3'd0) ? -11'sd1 : $signed({1'b0, dv_q[9:0]});

  // gesture decision for a sample
  always_comb begin
    close   = !samp[10] && (samp != 11'sd0) && (samp[9:0] < hold_near);
    ct_inc  = close ? ((close_ticks == TICK_CAP) ? close_ticks : close_ticks + 8'd1) : 8'd0;
    hold_ok = (ct_inc >= hold_ticks) && (f_n != 3'd0) && ((f_hi - f_lo) < hold_spread);
    wave_ok = (samples_seen >= 5'd10) && w_any && (w_chg >= 4'd4)
              && ((w_hi - w_lo) >= wave_amp);
    push_ok = (samples_seen >= 5'd8) && p_pos_v && (p_pos >= 4'd1) && (p_pos <= 4'd8)
              && p_bef_v && p_aft_v
              && ({1'b0, p_bef} >= {1'b0, p_lo} + {1'b0, push_dep})
              && ({1'b0, p_aft} >= {1'b0, p_lo} + {1'b0, push_dep});
    swipe_ok = (samples_seen >= 5'd6) && s_found;

    pg_h = pending;
    if (close) begin
      if (hold_ok) pg_h = G_HOLD;
    end else if (close_ticks != 8'd0 && pending == G_HOLD) begin
      pg_h = G_NONE;
    end

    pg_next   = pg_h;
    cool_next = 8'd0;
    if (cooldown != 8'd0) begin
      pg_next   = pending;
      cool_next = cooldown - 8'd1;
    end else if (pg_h != G_HOLD) begin
      if (wave_ok) begin
        pg_next = G_WAVE; cool_next = cool_ticks;
      end else if (push_ok) begin
        pg_next = G_PUSH; cool_next = cool_ticks;
      end else if (swipe_ok) begin
        pg_next = G_SWIPE; cool_next = cool_ticks;
      end
    end
  end

  // gesture state and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pending     <= G_NONE;
      close_ticks <= '0;
      cooldown    <= '0;
      avg_q       <= -11'sd1;
    end else if (cmd.finish) begin
      pending     <= pg_next;
      close_ticks <= ct_inc;
      cooldown    <= cool_next;
      avg_q       <= mean;
    end else if (cmd.poll) begin
      if (pending != G_HOLD) pending <= G_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      gesture    <= pg_next;
      hand_near  <= ct_inc >= NEAR_TICKS;
      average_cm <= mean;
    end else if (cmd.poll) begin
      gesture    <= pending;
      hand_near  <= close_ticks >= NEAR_TICKS;
      average_cm <= avg_q;
    end
  end

endmodule

// ===== design/dgc_ctrl.sv =====
// ----------------------------------------------------------------------------
// dgc_ctrl
// transaction sequencer: history scan, divider steps and result handoff
// ----------------------------------------------------------------------------
`include "distance_gesture_classifier_macros.svh"

module dgc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              opcode,
  output logic              out_valid,
  input  logic              out_ready,
  output dgc_pkg::dgc_cmd_t cmd
);
  import dgc_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0] state, state_next;
  logic [3:0] cnt, cnt_next;
  logic       is_poll, is_poll_next;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // next state and commands
  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    is_poll_next = is_poll;
    cmd          = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (opcode == OP_POLL) begin
            is_poll_next = 1'b1;
            state_next   = S_FIN;
          end else begin
            is_poll_next = 1'b0;
            cmd.start    = 1'b1;
            cnt_next     = '0;
            state_next   = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        cnt_next  = cnt + 4'd1;
        if (cnt == SCAN_LEN - 4'd1) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        cmd.div_init = 1'b1;
        cnt_next     = '0;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 4'd1;
        if (cnt == DIV_STEPS - 4'd1) state_next = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.finish = !is_poll;
          cmd.poll   = is_poll;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      is_poll   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      is_poll <= is_poll_next;
      if (cmd.finish || cmd.poll) out_valid <= 1'b1;
      else if (out_ready)         out_valid <= 1'b0;
    end
  end

  // checks
  `DGC_ASSERT_IMP(a_cmd_onehot, clk, rst, 1'b1, $onehot0(cmd))
  `DGC_ASSERT_NEXT(a_start_scans, clk, rst, cmd.start, state == S_SCAN && cnt == 4'd0)
  `DGC_ASSERT_IMP(a_result_slot_free, clk, rst, cmd.finish || cmd.poll, out_free)
  `DGC_ASSERT_IMP(a_scan_bound, clk, rst, state == S_SCAN, cnt < SCAN_LEN)

endmodule
